// ===== rtl/cqs_pkg.sv =====
// Shared types and constants for the circular queue with search.
package cqs_pkg;

  localparam int unsigned CFG_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 5;

  typedef enum logic [1:0] {
    FN_INSERT  = 2'd0,
    FN_DELETE  = 2'd1,
    FN_SEARCH  = 2'd2,
    FN_DISPLAY = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    func_e                    func;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic                     last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic    start;      // latch key, walk pointer to head
    logic    ins_first;  // insert into empty queue
    logic    ins_next;   // insert behind tail
    logic    pop;        // drop head
    logic    step;       // advance walk pointer
    logic    emit;       // load output register
    status_e emit_status;
    logic    emit_data;
    logic    emit_pos;
    logic    emit_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic at_tail;
    logic pos_max;
    logic match;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/cqs_ctrl.sv =====
// Controller state machine: sequences one operation per accepted item.
module cqs_ctrl import cqs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  func_e in_func_i,
  output logic  in_stall_o,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  func_e  func_q, func_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    func_d  = func_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          func_d      = in_func_i;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          case (func_q)
            FN_INSERT: begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              state_d         = S_IDLE;
              if (sts_i.empty) begin
                cmd_o.ins_first = 1'b1;
              end else if (sts_i.full) begin
                cmd_o.emit_status = ST_FULL;
              end else begin
                cmd_o.ins_next = 1'b1;
              end
            end
            FN_DELETE: begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              state_d         = S_IDLE;
              if (sts_i.empty) begin
                cmd_o.emit_status = ST_EMPTY;
              end else begin
                cmd_o.emit_data = 1'b1;
                cmd_o.pop       = 1'b1;
              end
            end
            FN_SEARCH: begin
              if (sts_i.empty) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_last   = 1'b1;
                cmd_o.emit_status = ST_EMPTY;
                state_d           = S_IDLE;
              end else if (sts_i.match) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_last = 1'b1;
                cmd_o.emit_pos  = 1'b1;
                state_d         = S_IDLE;
              end else if (sts_i.at_tail || sts_i.pos_max) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_last   = 1'b1;
                cmd_o.emit_status = ST_NOTFOUND;
                state_d           = S_IDLE;
              end else begin
                cmd_o.step = 1'b1;
              end
            end
            FN_DISPLAY: begin
              cmd_o.emit = 1'b1;
              if (sts_i.empty) begin
                cmd_o.emit_last   = 1'b1;
                cmd_o.emit_status = ST_EMPTY;
                state_d           = S_IDLE;
              end else begin
                cmd_o.emit_data = 1'b1;
                cmd_o.emit_last = sts_i.at_tail || sts_i.pos_max;
                if (sts_i.at_tail || sts_i.pos_max) begin
                  state_d = S_IDLE;
                end else begin
                  cmd_o.step = 1'b1;
                end
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/cqs_dp.sv =====
// Datapath: slot memory, head/tail indexes, walk pointer and output register.
module cqs_dp import cqs_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic signed [31:0] in_value_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > CFG_W) ? CW : CFG_W;

  logic signed [31:0] mem [DEPTH];

  logic [IW-1:0]      head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic               empty_q, empty_d;
  logic [CW-1:0]      cap_q, cap_d, pos_q, pos_d;
  logic signed [31:0] key_q, key_d, rd_data_q;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic [IW-1:0]      nxt_head, nxt_tail, nxt_ptr, wr_addr;
  logic               wr_en;
  logic [XW-1:0]      cfg_x;

  // wraps at the configured capacity
  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i,
                                             input logic [CW-1:0] cap);
    logic [IW:0] n;
    n = {1'b0, i} + (IW+1)'(1);
    return (n >= (IW+1)'(cap)) ? '0 : n[IW-1:0];
  endfunction

  assign nxt_head = next_idx(head_q, cap_q);
  assign nxt_tail = next_idx(tail_q, cap_q);
  assign nxt_ptr  = next_idx(ptr_q, cap_q);
  assign cfg_x    = XW'(cfg_data_i);

  assign sts_o.empty    = empty_q;
  assign sts_o.full     = (head_q == nxt_tail);
  assign sts_o.at_tail  = (ptr_q == tail_q);
  assign sts_o.pos_max  = (pos_q == CW'(DEPTH));
  assign sts_o.match    = (rd_data_q == key_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign wr_en   = cmd_i.ins_first || cmd_i.ins_next;
  assign wr_addr = cmd_i.ins_first ? '0 : nxt_tail;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    empty_d     = empty_q;
    cap_d       = cap_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    key_d       = key_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_we_i) begin
      if (cfg_x == '0) begin
        cap_d = CW'(1);
      end else if (cfg_x > XW'(DEPTH)) begin
        cap_d = CW'(DEPTH);
      end else begin
        cap_d = CW'(cfg_x);
      end
      head_d  = '0;
      tail_d  = '0;
      empty_d = 1'b1;
    end

    if (cmd_i.start) begin
      ptr_d = head_q;
      pos_d = CW'(1);
      key_d = in_value_i;
    end
    if (cmd_i.step) begin
      ptr_d = nxt_ptr;
      pos_d = pos_q + CW'(1);
    end
    if (cmd_i.ins_first) begin
      head_d  = '0;
      tail_d  = '0;
      empty_d = 1'b0;
    end
    if (cmd_i.ins_next) begin
      tail_d = nxt_tail;
    end
    if (cmd_i.pop) begin
      if (head_q == tail_q) begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b1;
      end else begin
        head_d = nxt_head;
      end
    end
    if (cmd_i.emit) begin
      out_valid_d     = 1'b1;
      out_d.status    = cmd_i.emit_status;
      out_d.data      = cmd_i.emit_data ? rd_data_q : '0;
      out_d.position  = cmd_i.emit_pos ? POS_W'(pos_q) : '0;
      out_d.last      = cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      cap_q       <= CW'(DEPTH < 16 ? DEPTH : 16);
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    pos_q <= pos_d;
    key_q <= key_d;
    out_q <= out_d;
  end

  // read follows the next walk pointer, so data for ptr_q is ready each cycle
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[ptr_d];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= key_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/circular_queue_with_search.sv =====
// Circular queue with search: top level joining controller and datapath.
// Insert/delete: S_IDLE takes the input, S_EXEC loads the result when output is free.
// Search and display walk one stored entry per cycle while the output is free, reading
// the slots; at most DEPTH entries are walked, and display emits a result for each.
// A new item is taken the cycle after the final result is loaded into the output register.
// Reset (async, active low) empties the queue, capacity = min(DEPTH, 16), slots undefined.
module circular_queue_with_search import cqs_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_o
);

  cmd_t cmd;
  sts_t sts;

  cqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_i.func),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_value_i  (in_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/cqs_checker.sv =====
// Port-level checker for the circular queue, bound to the top level.
module cqs_checker import cqs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_o
);

  // handshake: a stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result dropped or changed");

  // one item at a time: a transfer in closes the input the next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after a transfer");

  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != ST_OK) |->
      (out_o.data == '0) && (out_o.position == '0) && out_o.last)
    else $error("error result carries payload or is not last");

  a_pos_only_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.position != '0) |-> (out_o.data == '0) && out_o.last)
    else $error("search position with data or not last");

endmodule

bind circular_queue_with_search cqs_checker u_cqs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

// ===== bench/circular_queue_with_search_tb.sv =====
// Testbench for circular_queue_with_search: directed table plus random traffic vs a ring model.
`timescale 1ns / 1ps

module circular_queue_with_search_tb;
  import cqs_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned PHASE_OPS  = 24;
  localparam int unsigned IDLE_LIMIT = 2000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_t              in_i        = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_t             out_o;

  circular_queue_with_search #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Directed table: typed rows carry a status with zero data/position and last set.
  typedef struct packed {
    bit               is_cfg;
    logic [CFG_W-1:0] cap;
    func_e            func;
    logic [31:0]      value;
    bit               typed;
    status_e          status;
  } dir_row_t;

  dir_row_t dir_table [0:27] = '{
    '{1'b0, 5'd0,  FN_DELETE,  32'h0000_0000, 1'b1, ST_EMPTY},
    '{1'b0, 5'd0,  FN_SEARCH,  32'h0000_0000, 1'b1, ST_EMPTY},
    '{1'b0, 5'd0,  FN_DISPLAY, 32'h0000_0000, 1'b1, ST_EMPTY},
    '{1'b0, 5'd0,  FN_INSERT,  32'h8000_0000, 1'b1, ST_OK},
    '{1'b0, 5'd0,  FN_INSERT,  32'h7FFF_FFFF, 1'b1, ST_OK},
    '{1'b0, 5'd0,  FN_INSERT,  32'h0000_0000, 1'b1, ST_OK},
    '{1'b0, 5'd0,  FN_INSERT,  32'hFFFF_FFFF, 1'b1, ST_OK},
    '{1'b0, 5'd0,  FN_SEARCH,  32'h7FFF_FFFF, 1'b0, ST_OK},
    '{1'b0, 5'd0,  FN_SEARCH,  32'h0000_1234, 1'b0, ST_OK},
    '{1'b0, 5'd0,  FN_SEARCH,  32'hFFFF_FFFF, 1'b0, ST_OK},
    '{1'b0, 5'd0,  FN_DISPLAY, 32'h0000_0000, 1'b0, ST_OK},
    '{1'b0, 5'd0,  FN_DELETE,  32'h0000_0000, 1'b0, ST_OK},
    '{1'b0, 5'd0,  FN_DELETE,  32'h0000_0000, 1'b0, ST_OK},
    '{1'b0, 5'd0,  FN_DELETE,  32'h0000_0000, 1'b0, ST_OK},
    '{1'b0, 5'd0,  FN_DELETE,  32'h0000_0000, 1'b0, ST_OK},
    '{1'b0, 5'd0,  FN_DELETE,  32'h0000_0000, 1'b1, ST_EMPTY},
    '{1'b0, 5'd0,  FN_INSERT,  32'h5A5A_A5A5, 1'b1, ST_OK},
    '{1'b0, 5'd0,  FN_DISPLAY, 32'h0000_0000, 1'b0, ST_OK},
    '{1'b1, 5'd1,  FN_INSERT,  32'h0000_0000, 1'b0, ST_OK},
    '{1'b0, 5'd0,  FN_DISPLAY, 32'h0000_0000, 1'b1, ST_EMPTY},
    '{1'b0, 5'd0,  FN_INSERT,  32'h0000_0011, 1'b1, ST_OK},
    '{1'b0, 5'd0,  FN_INSERT,  32'h0000_0022, 1'b1, ST_FULL},
    '{1'b0, 5'd0,  FN_SEARCH,  32'h0000_0011, 1'b0, ST_OK},
    '{1'b1, 5'd0,  FN_INSERT,  32'h0000_0000, 1'b0, ST_OK},
    '{1'b0, 5'd0,  FN_INSERT,  32'h0000_0001, 1'b1, ST_OK},
    '{1'b0, 5'd0,  FN_INSERT,  32'h0000_0002, 1'b1, ST_FULL},
    '{1'b1, 5'd31, FN_INSERT,  32'h0000_0000, 1'b0, ST_OK},
    '{1'b0, 5'd0,  FN_SEARCH,  32'h0000_0001, 1'b1, ST_EMPTY}
  };

  // Ring model state
  logic [31:0] ring_slot [0:DEPTH-1];
  int unsigned ring_head, ring_tail, ring_cap;
  bit          ring_empty;

  out_t op_results [$];
  out_t pending_results [$];

  int unsigned errors, n_items, n_results, n_cfg;
  int unsigned n_full, n_empty, n_miss, n_hits;
  int unsigned idle_cycles, stall_left;
  bit          calm, tx_gap_on, rx_stall_on;

  function automatic int unsigned ring_next(input int unsigned i);
    int unsigned n;
    n = i + 1;
    return (n >= ring_cap || n >= DEPTH) ? 0 : n;
  endfunction

  function automatic void ring_set_capacity(input logic [CFG_W-1:0] v);
    int unsigned c;
    c = v;
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    ring_cap   = c;
    ring_head  = 0;
    ring_tail  = 0;
    ring_empty = 1'b1;
  endfunction

  function automatic out_t make_result(input status_e st, input logic [31:0] d,
                                       input logic [POS_W-1:0] pos, input logic fin);
    out_t r;
    r.status   = st;
    r.data     = d;
    r.position = pos;
    r.last     = fin;
    return r;
  endfunction

  // Fills op_results with what the queue answers to one request.
  function automatic void ring_apply(input in_t it);
    int unsigned f;
    bit          fin;
    op_results.delete();
    case (it.func)
      FN_INSERT: begin
        if (ring_empty) begin
          ring_head  = 0;
          ring_tail  = 0;
          ring_empty = 1'b0;
        end else if (ring_head == ring_next(ring_tail)) begin
          op_results.push_back(make_result(ST_FULL, '0, '0, 1'b1));
          return;
        end else begin
          ring_tail = ring_next(ring_tail);
        end
        ring_slot[ring_tail] = it.value;
        op_results.push_back(make_result(ST_OK, '0, '0, 1'b1));
      end
      FN_DELETE: begin
        if (ring_empty) begin
          op_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
          return;
        end
        op_results.push_back(make_result(ST_OK, ring_slot[ring_head], '0, 1'b1));
        if (ring_head == ring_tail) begin
          ring_head  = 0;
          ring_tail  = 0;
          ring_empty = 1'b1;
        end else begin
          ring_head = ring_next(ring_head);
        end
      end
      FN_SEARCH: begin
        if (ring_empty) begin
          op_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
          return;
        end
        f = ring_head;
        for (int unsigned pos = 1; pos <= DEPTH; pos++) begin
          if (ring_slot[f] == it.value) begin
            op_results.push_back(make_result(ST_OK, '0, pos[POS_W-1:0], 1'b1));
            return;
          end
          if (f == ring_tail) break;
          f = ring_next(f);
        end
        op_results.push_back(make_result(ST_NOTFOUND, '0, '0, 1'b1));
      end
      default: begin
        if (ring_empty) begin
          op_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
          return;
        end
        f = ring_head;
        for (int unsigned k = 0; k < DEPTH; k++) begin
          fin = (f == ring_tail) || (k == DEPTH - 1);
          op_results.push_back(make_result(ST_OK, ring_slot[f], '0, fin));
          if (fin) return;
          f = ring_next(f);
        end
      end
    endcase
  endfunction

  // Small values give duplicates so search must report the first match.
  function automatic logic [31:0] random_word();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r < 2) return 32'($urandom_range(0, 6)) - 32'd3;
    if (r == 2) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  function automatic in_t random_item(input int unsigned ins_pct);
    in_t         it;
    int unsigned r, n, f;
    it.value = random_word();
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      it.func = FN_INSERT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45)      it.func = FN_DELETE;
      else if (r < 80) it.func = FN_SEARCH;
      else             it.func = FN_DISPLAY;
    end
    // most searches look for something actually stored
    if (it.func == FN_SEARCH && !ring_empty && $urandom_range(0, 2) != 0) begin
      n = 1;
      f = ring_head;
      while (f != ring_tail) begin
        f = ring_next(f);
        n++;
      end
      f = ring_head;
      repeat ($urandom_range(0, n - 1)) f = ring_next(f);
      it.value = ring_slot[f];
    end
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR: %s", msg);
  endtask

  task automatic send_item(input in_t it, input bit typed, input status_e st);
    bit taken;
    in_i       <= it;
    in_valid_i <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    ring_apply(it);
    n_items++;
    if (typed) pending_results.push_back(make_result(st, '0, '0, 1'b1));
    else foreach (op_results[i]) pending_results.push_back(op_results[i]);
  endtask

  task automatic idle_gap();
    if (!calm && tx_gap_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Always advances the clock before returning, so valid is not lowered and raised in one step.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_data_i <= v;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    ring_set_capacity(v);
    n_cfg++;
  endtask

  // Random receiver stall bursts, enabled by rx_stall_on outside the calm phase
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && rx_stall_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Output payload is stable before the edge, so check it on the falling edge.
  always @(negedge clk_i) begin : check_result
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", n_results));
      end else begin
        want = pending_results.pop_front();
        if (out_o.status !== want.status)
          report_mismatch($sformatf("result %0d status: got %0d, expected %0d",
                                    n_results, out_o.status, want.status));
        if (out_o.data !== want.data)
          report_mismatch($sformatf("result %0d data: got %0d, expected %0d",
                                    n_results, out_o.data, want.data));
        if (out_o.position !== want.position)
          report_mismatch($sformatf("result %0d position: got %0d, expected %0d",
                                    n_results, out_o.position, want.position));
        if (out_o.last !== want.last)
          report_mismatch($sformatf("result %0d last: got %0b, expected %0b",
                                    n_results, out_o.last, want.last));
        case (want.status)
          ST_FULL:     n_full++;
          ST_EMPTY:    n_empty++;
          ST_NOTFOUND: n_miss++;
          default:     if (want.position != 0) n_hits++;
        endcase
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("circular_queue_with_search test failed");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] phase_cap [NUM_PHASES];
    int unsigned      phase_ins [NUM_PHASES];
    in_t              it;

    phase_cap = '{5'd16, 5'd1, 5'd2, 5'd3, 5'd7, 5'd0, 5'd31, 5'd16, 5'd20, 5'd16};
    phase_ins = '{80, 50, 50, 55, 60, 50, 75, 55, 55, 45};
    phase_cap[7] = 5'($urandom_range(1, 16));
    phase_cap[8] = 5'($urandom_range(17, 31));
    for (int i = 0; i < DEPTH; i++) ring_slot[i] = '0;
    ring_set_capacity(5'd16);
    tx_gap_on   = 1'b1;
    rx_stall_on = 1'b1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) begin
        write_capacity(dir_table[i].cap);
      end else begin
        it.func  = dir_table[i].func;
        it.value = dir_table[i].value;
        send_item(it, dir_table[i].typed, dir_table[i].status);
        idle_gap();
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(phase_cap[ph]);
      tx_gap_on   = (ph % 4 != 1);
      rx_stall_on = (ph % 3 != 2);
      calm        = (ph == NUM_PHASES - 1);
      for (int n = 0; n < PHASE_OPS; n++) begin
        send_item(random_item(phase_ins[ph]), 1'b0, ST_OK);
        // one mid-phase hold-off until the queue has answered everything
        if (ph == 2 && n == PHASE_OPS / 2) wait_drained();
        else idle_gap();
      end
    end

    wait_drained();
    repeat (DEPTH + 8) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Covered %0d requests, %0d results, %0d capacity writes", n_items, n_results,
             n_cfg);
    $display("Replies seen: %0d full, %0d empty, %0d search hits, %0d misses", n_full,
             n_empty, n_hits, n_miss);
    if (errors == 0) begin
      $display("circular_queue_with_search test passed");
    end else begin
      $display("circular_queue_with_search test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cqs_pkg.sv
rtl/cqs_ctrl.sv
rtl/cqs_dp.sv
rtl/circular_queue_with_search.sv
rtl/cqs_checker.sv
bench/circular_queue_with_search_tb.sv
